### design/mtd_pkg.sv
// Shared types, code table and decode function for the Morse text decoder.
`timescale 1ns / 1ps
`default_nettype none
package mtd_pkg;

    localparam int MTD_KEPT_SYMBOLS = 5;
    localparam int MTD_COUNT_MAX    = 7;
    localparam int MTD_CODE_ENTRIES = 36;
    localparam int MTD_QUEUE_DEPTH  = 4;

    // ASCII codes the block recognizes or produces
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_QMARK  = 8'h3F;

    // Token descriptor handed from front to back
    typedef struct packed {
        logic       bad;
        logic       slash;
        logic [2:0] count;
        logic [4:0] bits;
    } t_token;

    // Decoded character
    typedef struct packed {
        logic [7:0] text_char;
        logic       unknown_code;
    } t_result;

    // Symbol i of a code in bit i, 1 = dash
    localparam logic [4:0] CODE_PAT [MTD_CODE_ENTRIES] = '{
        5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
        5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
        5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
        5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
        5'b01101, 5'b00011,
        5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000, 5'b00000,
        5'b00001, 5'b00011, 5'b00111, 5'b01111
    };

    localparam logic [2:0] CODE_LEN [MTD_CODE_ENTRIES] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
        3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    localparam logic [7:0] CODE_CHAR [MTD_CODE_ENTRIES] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
        8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
    };

    // Map a finished token to its character; '?' when nothing matches
    function automatic t_result mtd_decode(input t_token tok);
        t_result res;
        res.text_char    = CHAR_QMARK;
        res.unknown_code = 1'b1;
        if (tok.bad) begin
            res.text_char    = CHAR_QMARK;
            res.unknown_code = 1'b1;
        end else if (tok.slash) begin
            res.text_char    = CHAR_SPACE;
            res.unknown_code = 1'b0;
        end else begin
            for (int e = 0; e < MTD_CODE_ENTRIES; e++) begin
                if (tok.count == CODE_LEN[e] && tok.bits == CODE_PAT[e]) begin
                    res.text_char    = CODE_CHAR[e];
                    res.unknown_code = 1'b0;
                end
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### design/mtd_front.sv
// Front end: accepts bytes, builds the current token, queues finished tokens.
`timescale 1ns / 1ps
`default_nettype none
module mtd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_in_char,
    input  wire logic          i_end_of_message,
    input  wire logic          i_queue_full,
    output logic               o_push,
    output mtd_pkg::t_token    o_token
);
    import mtd_pkg::*;

    logic [4:0] r_bits,  n_bits;
    logic [2:0] r_count, n_count;
    logic       r_slash, n_slash;
    logic       r_bad,   n_bad;
    logic       accept;
    logic       is_sep;
    logic       pending;
    t_token     cur_tok;
    t_token     upd_tok;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the incoming byte
    assign is_sep  = (i_in_char == CHAR_SPACE) ||
                     (i_in_char >= CHAR_TAB && i_in_char <= CHAR_CR);
    assign pending = (r_count != 3'd0) || r_slash || r_bad;

    // Fold the byte into the token
    always_comb begin
        upd_tok.bits  = r_bits;
        upd_tok.count = r_count;
        upd_tok.slash = r_slash;
        upd_tok.bad   = r_bad;
        if (i_in_char == CHAR_DOT || i_in_char == CHAR_DASH) begin
            if (r_slash) begin
                upd_tok.bad = 1'b1;
            end
            if (r_count < 3'(MTD_KEPT_SYMBOLS) && i_in_char == CHAR_DASH) begin
                upd_tok.bits = r_bits | (5'd1 << r_count);
            end
            if (r_count < 3'(MTD_COUNT_MAX)) begin
                upd_tok.count = r_count + 3'd1;
            end
        end else if (i_in_char == CHAR_SLASH) begin
            if (!pending) begin
                upd_tok.slash = 1'b1;
            end else begin
                upd_tok.bad = 1'b1;
            end
        end else begin
            upd_tok.bad = 1'b1;
        end
    end

    assign cur_tok = '{bad: r_bad, slash: r_slash, count: r_count, bits: r_bits};

    // Flush at a separator with a pending token, or on a last byte that is not a separator
    assign o_push  = accept && (is_sep ? pending : i_end_of_message);
    assign o_token = is_sep ? cur_tok : upd_tok;

    always_comb begin
        n_bits  = r_bits;
        n_count = r_count;
        n_slash = r_slash;
        n_bad   = r_bad;
        if (accept) begin
            if (is_sep || i_end_of_message) begin
                n_bits  = '0;
                n_count = '0;
                n_slash = 1'b0;
                n_bad   = 1'b0;
            end else begin
                n_bits  = upd_tok.bits;
                n_count = upd_tok.count;
                n_slash = upd_tok.slash;
                n_bad   = upd_tok.bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_count <= '0;
            r_slash <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_bits  <= n_bits;
            r_count <= n_count;
            r_slash <= n_slash;
            r_bad   <= n_bad;
        end
    end

endmodule
`default_nettype wire

### design/mtd_queue.sv
// Short token queue between the front end and the decode stage.
`timescale 1ns / 1ps
`default_nettype none
module mtd_queue #(
    parameter int DEPTH = mtd_pkg::MTD_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mtd_pkg::t_token i_token,
    input  wire logic          i_pop,
    output mtd_pkg::t_token    o_token,
    output logic               o_full,
    output logic               o_empty
);
    import mtd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_token = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("token queue count exceeds depth");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty token queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push without pop did not grow the queue");

endmodule
`default_nettype wire

### design/mtd_back.sv
// Back end: decodes queued tokens into the registered output word.
`timescale 1ns / 1ps
`default_nettype none
module mtd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mtd_pkg::t_token i_token,
    input  wire logic          i_queue_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_text_char,
    output logic               o_unknown_code
);
    import mtd_pkg::*;

    logic       r_valid, n_valid;
    logic [7:0] r_text_char;
    logic       r_unknown;
    t_result    dec;

    // Load a new word when the output slot is free or being taken
    assign o_pop = !i_queue_empty && (!r_valid || i_out_ready);
    assign dec   = mtd_decode(i_token);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_text_char <= dec.text_char;
            r_unknown   <= dec.unknown_code;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_text_char    = r_text_char;
    assign o_unknown_code = r_unknown;

    a_unknown_is_qmark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unknown_code) |-> (o_text_char == CHAR_QMARK))
        else $error("unknown flag set on a decoded character");

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_out_valid)
        else $error("popped token did not reach the output");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_text_char)
            && $stable(o_unknown_code)))
        else $error("output word changed while stalled");

endmodule
`default_nettype wire

### design/morse_text_decoder_top.sv
// Top level of the Morse text decoder: front end, token queue, decode stage.
//
// Input channel: one ASCII byte per word (i_in_char) with i_end_of_message
// on the last byte, handshaked by i_in_valid / o_in_ready. Dots, dashes and
// slashes build a token; whitespace or the last byte ends it.
// Output channel: one decoded character per finished token (o_text_char,
// o_unknown_code), handshaked by o_out_valid / i_out_ready.
// Throughput: one input word per cycle while the token queue is not full. A
// token that ends on an accepted word passes through the token queue and
// then the decode stage's output register before it shows at the output.
// Stalls: the queue holds QUEUE_DEPTH finished tokens; o_in_ready drops only
// while it is full, so bytes keep flowing while the receiver stalls until
// QUEUE_DEPTH + 1 characters are waiting (queue plus output register).
// Reset (i_rst_n low, synchronous) clears the pending token, empties the
// queue and drops o_out_valid.
`timescale 1ns / 1ps
`default_nettype none
module morse_text_decoder_top #(
    parameter int QUEUE_DEPTH = mtd_pkg::MTD_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_end_of_message,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_text_char,
    output logic            o_unknown_code
);
    import mtd_pkg::*;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    t_token push_tok;
    t_token head_tok;

    mtd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_char        (i_in_char),
        .i_end_of_message (i_end_of_message),
        .i_queue_full     (q_full),
        .o_push           (push),
        .o_token          (push_tok)
    );

    mtd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_tok),
        .i_pop   (pop),
        .o_token (head_tok),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mtd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_token        (head_tok),
        .i_queue_empty  (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_text_char    (o_text_char),
        .o_unknown_code (o_unknown_code)
    );

endmodule
`default_nettype wire
